/* hdl/error_bounded_delta_block_compressor_macros.svh */
// Assertion macros shared by the compressor's checker.
`ifndef ERROR_BOUNDED_DELTA_BLOCK_COMPRESSOR_MACROS_SVH
`define ERROR_BOUNDED_DELTA_BLOCK_COMPRESSOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define EBDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define EBDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ebdc_pkg.sv */
// Types, constants and codes shared by the compressor modules.
package ebdc_pkg;

  localparam int EBDC_MAX_BLOCK = 8;
  localparam int EBDC_FRAC_BITS = 16;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BOUND = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 4'd1;

  localparam logic [31:0] INV_BOUND_RST = 32'd65536;
  localparam logic [3:0]  BLOCK_LEN_RST = 4'd8;

  // byte source select for the output mux
  localparam logic [1:0] SRC_RAW  = 2'd0;
  localparam logic [1:0] SRC_HDR  = 2'd1;
  localparam logic [1:0] SRC_SIGN = 2'd2;
  localparam logic [1:0] SRC_MAG  = 2'd3;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_sample;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       segment_end;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       qnt;
    logic       upd;
    logic       hdr;
    logic       emit;
    logic [1:0] src;
    logic       run_end;
    logic       finish;
  } ebdc_cmd_t;

  typedef struct packed {
    logic have_first;
    logic send;
    logic hdr_zero;
    logic raw_done;
    logic sign_done;
    logic mag_done;
    logic emit_ok;
  } ebdc_stat_t;

endpackage

/* hdl/ebdc_ctrl.sv */
// Sequencer for the compressor: quantize, update block, emit bytes.
module ebdc_ctrl import ebdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ebdc_stat_t stat,
  output ebdc_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_QNT  = 4'd2;
  localparam logic [3:0] S_UPD  = 4'd3;
  localparam logic [3:0] S_HDR  = 4'd4;
  localparam logic [3:0] S_RAW  = 4'd5;
  localparam logic [3:0] S_BHDR = 4'd6;
  localparam logic [3:0] S_SIGN = 4'd7;
  localparam logic [3:0] S_MAG  = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.src   = SRC_HDR;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_QNT;
      end
      S_QNT: begin
        cmd.qnt   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        priority if (!stat.have_first) begin
          state_nxt = S_RAW;
        end else if (stat.send) begin
          state_nxt = S_HDR;
        end else begin
          state_nxt = S_IDLE;  // delta buffered only, nothing to send
        end
      end
      S_HDR: begin
        cmd.hdr   = 1'b1;
        state_nxt = S_BHDR;
      end
      S_RAW: begin
        cmd.src = SRC_RAW;
        if (stat.emit_ok) begin
          cmd.emit = 1'b1;
          if (stat.raw_done) begin
            cmd.run_end = 1'b1;
            cmd.finish  = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_BHDR: begin
        cmd.src = SRC_HDR;
        if (stat.emit_ok) begin
          cmd.emit = 1'b1;
          if (stat.hdr_zero) begin
            cmd.run_end = 1'b1;
            cmd.finish  = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        cmd.src = SRC_SIGN;
        if (stat.emit_ok) begin
          cmd.emit = 1'b1;
          if (stat.sign_done) begin
            state_nxt = S_MAG;
          end
        end
      end
      S_MAG: begin
        cmd.src = SRC_MAG;
        if (stat.emit_ok) begin
          cmd.emit = 1'b1;
          if (stat.mag_done) begin
            cmd.run_end = 1'b1;
            cmd.finish  = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/ebdc_dp.sv */
// Datapath: quantizer, delta block buffer, byte formatter, output register.
module ebdc_dp import ebdc_pkg::*; #(
  parameter int MAX_BLOCK = EBDC_MAX_BLOCK,
  parameter int FRAC_BITS = EBDC_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_t         in_data,
  input  logic [31:0] inv_bound,
  input  logic [3:0]  blk_len,
  input  ebdc_cmd_t   cmd,
  output ebdc_stat_t  stat,
  input  logic        out_ready,
  output logic        out_valid,
  output out_t        out_data
);

  localparam int FW = $clog2(MAX_BLOCK + 1);
  localparam int IW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int SB = (MAX_BLOCK + 7) / 8;
  localparam int SW = (SB > 1) ? $clog2(SB) : 1;
  localparam int SH = 2 * FRAC_BITS;

  // bit length of v: highest nonzero byte, then highest set bit in it
  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [1:0]  hi;
    logic [31:0] vs;
    logic [7:0]  b;
    logic [2:0]  p;
    hi = (v[31:24] != 8'd0) ? 2'd3 :
         (v[23:16] != 8'd0) ? 2'd2 :
         (v[15:8]  != 8'd0) ? 2'd1 : 2'd0;
    vs = v >> {hi, 3'b000};
    b  = vs[7:0];
    p  = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = 3'(i);
    end
    return (b == 8'd0) ? 6'd0 : ({1'b0, hi, 3'b000} + {3'b000, p} + 6'd1);
  endfunction

  in_t           in_r;
  logic          neg_r;
  logic [63:0]   prod_r;
  logic [31:0]   q_r;
  logic [31:0]   prior_r;
  logic          have_first_r;
  logic          send_r;
  logic [FW-1:0] fill_r;
  logic [31:0]   max_r;
  logic [MAX_BLOCK-1:0] sign_r;
  logic [31:0]   mag_r [MAX_BLOCK];
  logic [5:0]    hdr_r;
  logic [1:0]    bidx_r;
  logic [IW-1:0] eidx_r;
  logic [SW-1:0] sidx_r;
  out_t          out_r;
  logic          out_valid_r;

  logic [31:0]   mag32;
  logic [63:0]   prod_nxt;
  logic [63:0]   shv;
  logic [31:0]   q_nxt;
  logic [31:0]   dlt;
  logic [31:0]   dmag;
  logic [FW-1:0] fill_inc;
  logic [FW-1:0] fill_m1;
  logic [4:0]    len5;
  logic [1:0]    nb;
  logic [SB*8-1:0] spad;
  logic [SB*8-1:0] sw;
  logic [7:0]    sbyte;
  logic [31:0]   mw;
  logic [31:0]   rw;
  logic [7:0]    byte_sel;

  // quantizer: |sample| * inverse bound, shift, saturate
  always_comb begin
    mag32    = in_r.sample[31] ? (~in_r.sample + 32'd1) : in_r.sample;
    prod_nxt = 64'(mag32) * 64'(inv_bound);
    shv      = prod_r >> SH;
    if (!neg_r) begin
      q_nxt = (shv > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : shv[31:0];
    end else begin
      q_nxt = (shv > 64'h8000_0000) ? 32'h8000_0000 : (~shv[31:0] + 32'd1);
    end
  end

  // delta and block bookkeeping
  always_comb begin
    dlt      = q_r - prior_r;
    dmag     = dlt[31] ? (~dlt + 32'd1) : dlt;
    fill_inc = fill_r + FW'(1);
    fill_m1  = fill_r - FW'(1);
    priority if (blk_len == 4'd0) begin
      len5 = 5'd1;
    end else if ({1'b0, blk_len} > 5'(MAX_BLOCK)) begin
      len5 = 5'(MAX_BLOCK);
    end else begin
      len5 = {1'b0, blk_len};
    end
    nb = hdr_r[5] ? 2'd3 : hdr_r[4:3];
  end

  // byte formatting
  always_comb begin
    spad = '0;
    for (int i = 0; i < MAX_BLOCK; i++) begin
      spad[i] = sign_r[i] & (FW'(i) < fill_r);
    end
    sw = spad >> {sidx_r, 3'b000};
    for (int p = 0; p < 8; p++) begin
      sbyte[7-p] = sw[p];
    end
    mw = mag_r[eidx_r] >> {bidx_r, 3'b000};
    rw = q_r >> {bidx_r, 3'b000};
    unique case (cmd.src)
      SRC_RAW:  byte_sel = rw[7:0];
      SRC_HDR:  byte_sel = {2'b00, hdr_r};
      SRC_SIGN: byte_sel = sbyte;
      SRC_MAG:  byte_sel = mw[7:0];
    endcase
  end

  always_comb begin
    stat.have_first = have_first_r;
    stat.send       = have_first_r &&
                      ((5'(fill_inc) >= len5) || in_r.last_sample);
    stat.hdr_zero   = (hdr_r == 6'd0);
    stat.raw_done   = (bidx_r == 2'd3);
    stat.sign_done  = (FW'(sidx_r) == (fill_m1 >> 3));
    stat.mag_done   = (bidx_r == nb) && (FW'(eidx_r) == fill_m1);
    stat.emit_ok    = !out_valid_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      send_r       <= 1'b0;
      fill_r       <= '0;
      max_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.upd) begin
        have_first_r <= 1'b1;
        send_r       <= stat.send;
        if (have_first_r) begin
          fill_r <= fill_inc;
          if (dmag > max_r) max_r <= dmag;
        end
      end
      if (cmd.finish) begin
        if (send_r || in_r.last_sample) begin
          fill_r <= '0;
          max_r  <= '0;
        end
        if (in_r.last_sample) have_first_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.mul) begin
      prod_r <= prod_nxt;
      neg_r  <= in_r.sample[31];
    end
    if (cmd.qnt) q_r <= q_nxt;
    if (cmd.upd) begin
      prior_r <= q_r;
      bidx_r  <= '0;
      eidx_r  <= '0;
      sidx_r  <= '0;
      if (have_first_r) begin
        sign_r[fill_r[IW-1:0]] <= dlt[31];
        mag_r[fill_r[IW-1:0]]  <= dmag;
      end
    end
    if (cmd.hdr) hdr_r <= bit_len(max_r);
    if (cmd.emit) begin
      out_r.out_byte    <= byte_sel;
      out_r.run_end     <= cmd.run_end;
      out_r.segment_end <= cmd.run_end & in_r.last_sample;
      unique case (cmd.src)
        SRC_RAW:  bidx_r <= bidx_r + 2'd1;
        SRC_HDR:  ;
        SRC_SIGN: sidx_r <= sidx_r + SW'(1);
        SRC_MAG: begin
          if (bidx_r == nb) begin
            bidx_r <= '0;
            eidx_r <= eidx_r + IW'(1);
          end else begin
            bidx_r <= bidx_r + 2'd1;
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/error_bounded_delta_block_compressor.sv */
// Per item: load, multiply, quantize, update, then result bytes; a block also takes a header lookup.
// Throughput: one item at a time; a new input is taken only when the sequencer is back in idle
//   (up to 34 bytes per full block).
// Bytes leave at one per cycle through the single output register while out_ready holds.
// Reset (rst_n low, synchronous): sequencer idle, segment and block state cleared,
//   inverse_bound back to 65536, block_len back to 8.
module error_bounded_delta_block_compressor import ebdc_pkg::*; #(
  parameter int MAX_BLOCK = EBDC_MAX_BLOCK,
  parameter int FRAC_BITS = EBDC_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // configuration registers; writes are always taken, unknown indexes dropped
  logic [31:0] inv_bound_r;
  logic [3:0]  block_len_r;

  ebdc_cmd_t  cmd;
  ebdc_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_bound_r <= INV_BOUND_RST;
      block_len_r <= BLOCK_LEN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_INV_BOUND) inv_bound_r <= cfg_data;
      if (cfg_index == REG_BLOCK_LEN) block_len_r <= cfg_data[3:0];
    end
  end

  // sequencer: one item in flight, steps quantize -> update -> emit
  ebdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: multiplier, delta buffer, header/sign/magnitude byte mux
  ebdc_dp #(
    .MAX_BLOCK (MAX_BLOCK),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .inv_bound (inv_bound_r),
    .blk_len   (block_len_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* hdl/ebdc_chk.sv */
// Port-level checker for the compressor, bound to the top level.
`include "error_bounded_delta_block_compressor_macros.svh"

module ebdc_chk import ebdc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `EBDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped")
  `EBDC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "payload moved")
  `EBDC_ASSERT_SAME(a_seg, out_valid && out_data.segment_end, out_data.run_end, "lone seg end")
  `EBDC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second input taken while busy")

endmodule

bind error_bounded_delta_block_compressor ebdc_chk u_chk (.*);

/* dv/tb_error_bounded_delta_block_compressor.sv */
// Self-checking testbench for the error-bounded delta block compressor.
`timescale 1ns / 1ps

module tb_error_bounded_delta_block_compressor;
  import ebdc_pkg::*;

  // Run limit covers the worst case: 34 bytes per item, each behind a receiver
  // stall, plus sender gaps and config pauses, several times over.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int IDLE_PAUSE   = 16;   // covers an item that only buffers a delta
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 500;

  // Any index past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

  // Bit-accurate model of the byte stream plus the queue of bytes still owed.
  class ebdc_stream_model;
    logic [31:0] inv_bound;
    logic [3:0]  blk_len;
    logic [31:0] prior_q;
    bit          have_first;
    bit          sign_bits [EBDC_MAX_BLOCK];
    logic [31:0] mags [EBDC_MAX_BLOCK];
    int          fill;
    logic [31:0] blk_max;
    out_t        run_bytes[$];
    out_t        expected_bytes[$];
    int          mismatches;
    int          checked;

    function new();
      inv_bound  = INV_BOUND_RST;
      blk_len    = BLOCK_LEN_RST;
      prior_q    = '0;
      have_first = 1'b0;
      fill       = 0;
      blk_max    = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void mirror_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == REG_INV_BOUND) begin
        inv_bound = data;
      end else if (idx == REG_BLOCK_LEN) begin
        blk_len = data[3:0];
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction

    // sample * inverse_bound / 2^(2*FRAC), toward zero, clamped to 32 bits
    function logic [31:0] quantize(logic [31:0] raw);
      logic        neg;
      logic [31:0] mag;
      logic [63:0] prod;
      neg  = raw[31];
      mag  = neg ? (32'd0 - raw) : raw;
      prod = ({32'd0, mag} * {32'd0, inv_bound}) >> (2 * EBDC_FRAC_BITS);
      if (!neg) begin
        if (prod > 64'h7FFF_FFFF) prod = 64'h7FFF_FFFF;
        return prod[31:0];
      end
      if (prod > 64'h8000_0000) prod = 64'h8000_0000;
      return 32'd0 - prod[31:0];
    endfunction

    function int used_bits(logic [31:0] v);
      for (int i = 31; i >= 0; i--) begin
        if (v[i]) return i + 1;
      end
      return 0;
    endfunction

    function void emit_byte(logic [7:0] b);
      out_t o;
      o.out_byte    = b;
      o.run_end     = 1'b0;
      o.segment_end = 1'b0;
      run_bytes.push_back(o);
    endfunction

    function void flush_block();
      int         hdr;
      logic [7:0] acc;
      int         pos;
      int         nbytes;
      hdr = used_bits(blk_max);
      emit_byte(8'(hdr));
      if (hdr != 0) begin
        acc = '0;
        pos = 0;
        // sign bits, first delta in the MSB, zero padded
        for (int i = 0; i < fill; i++) begin
          acc[7 - pos] = sign_bits[i];
          pos++;
          if (pos == 8 || i + 1 == fill) begin
            emit_byte(acc);
            acc = '0;
            pos = 0;
          end
        end
        nbytes = (hdr < 8) ? 1 : (hdr < 16) ? 2 : (hdr < 24) ? 3 : 4;
        for (int i = 0; i < fill; i++) begin
          for (int b = 0; b < nbytes; b++) begin
            emit_byte(mags[i][8*b +: 8]);
          end
        end
      end
      fill    = 0;
      blk_max = '0;
    endfunction

    // One accepted sample: queue the bytes it must produce.
    function void note_sample(in_t item);
      logic [31:0] q;
      logic [31:0] d;
      logic [31:0] mag;
      logic        neg;
      int          len;
      out_t        tail;
      len = blk_len;
      if (len == 0) len = 1;
      if (len > EBDC_MAX_BLOCK) len = EBDC_MAX_BLOCK;
      q = quantize(item.sample);
      run_bytes.delete();
      if (!have_first) begin
        for (int b = 0; b < 4; b++) begin
          emit_byte(q[8*b +: 8]);
        end
        have_first = 1'b1;
      end else begin
        d   = q - prior_q;
        neg = d[31];
        mag = neg ? (32'd0 - d) : d;
        if (fill < EBDC_MAX_BLOCK) begin
          sign_bits[fill] = neg;
          mags[fill]      = mag;
          fill++;
        end
        if (mag > blk_max) blk_max = mag;
        if (fill >= len) flush_block();
      end
      prior_q = q;
      if (item.last_sample) begin
        if (fill > 0) flush_block();
        have_first = 1'b0;
        fill       = 0;
        blk_max    = '0;
      end
      if (run_bytes.size() > 0) begin
        tail             = run_bytes.pop_back();
        tail.run_end     = 1'b1;
        tail.segment_end = item.last_sample;
        run_bytes.push_back(tail);
      end
      foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < 40) $display("[%0t] %s", $time, msg);
      mismatches++;
    endtask

    task check_byte(out_t got);
      out_t want;
      checked++;
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("byte %0d: 0x%02h arrived with nothing owed",
                                checked, got.out_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        flag_mismatch($sformatf("byte %0d out_byte: got 0x%02h, want 0x%02h",
                                checked, got.out_byte, want.out_byte));
      if (got.run_end !== want.run_end)
        flag_mismatch($sformatf("byte %0d run_end: got %b, want %b",
                                checked, got.run_end, want.run_end));
      if (got.segment_end !== want.segment_end)
        flag_mismatch($sformatf("byte %0d segment_end: got %b, want %b",
                                checked, got.segment_end, want.segment_end));
    endtask
  endclass

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_EVERY_K, RDY_MOSTLY} ready_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  ebdc_stream_model model;
  int          cycles      = 0;
  int          burst_left  = 0;
  bit          steady      = 1'b0;  // phase without sender gaps
  bit          seg_start   = 1'b1;
  bit          flat_seg    = 1'b0;
  logic [31:0] last_driven = '0;
  ready_mode_t ready_mode  = RDY_ALWAYS;
  int          mode_left   = 0;
  int          stall_k     = 2;

  error_bounded_delta_block_compressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("error_bounded_delta_block_compressor: mismatch");
      $finish;
    end
  end

  // Receiver back-pressure: the pattern is redrawn whenever mode_left runs out,
  // between always ready, coin flips, one-in-k and mostly ready.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(50, 400);
      stall_k    <= $urandom_range(2, 8);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS:  out_ready <= 1'b1;
      RDY_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RDY_EVERY_K: out_ready <= ((cycles % stall_k) == 0);
      default:     out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Every byte transfer is checked against the oldest owed byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) model.check_byte(out_data);
  end

  // Send one sample. The sender runs in bursts; between bursts it may drop
  // valid for a random gap unless the phase is steady.
  task automatic push_sample(input logic [31:0] s, input logic last);
    in_t item;
    int  gap;
    item.sample      = s;
    item.last_sample = last;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    model.note_sample(item);
    burst_left--;
    last_driven = s;
  endtask

  // Stop input, let every owed byte drain, then allow for a buffer-only
  // item still in flight before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (model.outstanding() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    model.mirror_write(idx, data);
  endtask

  // Both registers back to back; upper bits of the length word are junk.
  task automatic configure(input logic [31:0] inv, input logic [3:0] len,
                           input bit poke_unused);
    settle();
    if (poke_unused) cfg_write(REG_UNUSED, $urandom());
    cfg_write(REG_INV_BOUND, inv);
    cfg_write(REG_BLOCK_LEN, ($urandom() & 32'hFFFF_FFF0) | {28'd0, len});
    cfg_valid <= 1'b0;
  endtask

  // Mostly small walks from the previous sample so headers spread over all
  // widths; some flat segments to make all-zero blocks; some wild values.
  task automatic random_item();
    logic [31:0] s;
    logic [31:0] step;
    logic        last;
    int          pick;
    if (seg_start) flat_seg = ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 9);
    step = $urandom() >> $urandom_range(0, 31);
    if (flat_seg && pick < 8) begin
      s = last_driven;
    end else begin
      case (pick)
        0: s = $urandom();
        1: begin
          case ($urandom_range(0, 3))
            0:       s = 32'h7FFF_FFFF;
            1:       s = 32'h8000_0000;
            2:       s = '0;
            default: s = '1;
          endcase
        end
        2:       s = last_driven;
        default: s = $urandom_range(0, 1) ? last_driven + step : last_driven - step;
      endcase
    end
    last = ($urandom_range(0, 11) == 0);
    push_sample(s, last);
    seg_start = last;
  endtask

  initial begin
    logic [31:0] inv;
    logic [3:0]  len;
    int          sent;
    int          n;
    model = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings. Full-scale samples, zero and +/-1 LSB, short final
    // block flushed by the segment end.
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0001_0000, 1'b0);
    push_sample(32'hFFFF_0000, 1'b0);
    push_sample(32'h1234_5678, 1'b0);
    push_sample(32'hDEAD_BEEF, 1'b1);
    // Segment of a single sample: raw bytes only.
    push_sample(32'h5A5A_A5A5, 1'b1);
    // Flat segment: one full all-zero block, header only, on the last sample.
    repeat (8) push_sample(32'h0003_0000, 1'b0);
    push_sample(32'h0003_0000, 1'b1);

    // Largest gain, one delta per block; 1 then -(2^31-1) gives the -2^31 delta.
    configure(32'hFFFF_FFFF, 4'd1, 1'b1);
    push_sample(32'h0000_0002, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1);

    // Smallest gain quantizes everything to zero; length 0 acts as 1.
    configure(32'h0000_0001, 4'd0, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1);

    // Length 15 clamps to the maximum; three deltas sit in the block when
    // the length drops to 2, so the next delta sends all four.
    configure(INV_BOUND_RST, 4'd15, 1'b0);
    push_sample(32'h0001_0000, 1'b0);
    push_sample(32'h0002_0000, 1'b0);
    push_sample(32'hFFFC_0000, 1'b0);
    push_sample(32'h0008_0000, 1'b0);
    configure(INV_BOUND_RST, 4'd2, 1'b0);
    push_sample(32'h0100_0000, 1'b1);

    // Random phases; segments run across register changes on purpose.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       inv = INV_BOUND_RST;
        1:       inv = 32'hFFFF_FFFF;
        2:       inv = 32'h0000_0001;
        3:       inv = $urandom_range(1, 32'h0004_0000);
        4:       inv = $urandom() | 32'd1;
        default: inv = 32'd1 << $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 3) == 0) len = 4'($urandom_range(0, 15));
      else                           len = 4'($urandom_range(1, EBDC_MAX_BLOCK));
      configure(inv, len, $urandom_range(0, 7) == 0);
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      repeat (n) random_item();
      sent += n;
    end

    // Drain, then give any stray byte time to show up.
    in_valid <= 1'b0;
    while (model.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.mismatches == 0) begin
      $display("error_bounded_delta_block_compressor: match");
    end else begin
      $display("error_bounded_delta_block_compressor: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ebdc_pkg.sv
hdl/ebdc_ctrl.sv
hdl/ebdc_dp.sv
hdl/error_bounded_delta_block_compressor.sv
hdl/ebdc_chk.sv
dv/tb_error_bounded_delta_block_compressor.sv
